// ----- hdl/etr_pkg.sv -----
// shared types, widths and constants for the euler-angle to rotation matrix pipeline
// no dependencies; used by etr_sincos and euler_to_rotation_matrix_top
package etr_pkg;

  localparam int AngW        = 16;  // Q2.13 input angle
  localparam int ZW          = 20;  // cordic residual angle, Q.16
  localparam int CordW       = 34;  // cordic x/y, Q.30 with headroom
  localparam int TrigW       = 22;  // narrowed sine/cosine, Q.20 in [-1, 1]
  localparam int OutW        = 16;  // Q1.14 matrix entry
  localparam int WideW       = 64;  // Q.60 accumulation
  localparam int NumEntries  = 9;

  localparam int CordicSteps   = 17;
  localparam int SinCosStages  = CordicSteps + 2;  // reduce, steps, narrow
  localparam int ProdStages    = 5;
  localparam int NumStages     = SinCosStages + ProdStages;

  localparam logic signed [AngW-1:0]  AngPi      = 16'sd25736;
  localparam logic signed [AngW-1:0]  AngHalfPi  = 16'sd12868;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;

  typedef logic signed [AngW-1:0]  angle_t;
  typedef logic signed [ZW-1:0]    zang_t;
  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [TrigW-1:0] trig_t;

  // atan(2^-i) in Q.16, rounded
  function automatic zang_t atan_q16(input int i);
    zang_t r;
    case (i)
      0:       r = 20'sd51472;
      1:       r = 20'sd30386;
      2:       r = 20'sd16055;
      3:       r = 20'sd8150;
      4:       r = 20'sd4091;
      5:       r = 20'sd2047;
      6:       r = 20'sd1024;
      7:       r = 20'sd512;
      8:       r = 20'sd256;
      9:       r = 20'sd128;
      10:      r = 20'sd64;
      11:      r = 20'sd32;
      12:      r = 20'sd16;
      13:      r = 20'sd8;
      14:      r = 20'sd4;
      15:      r = 20'sd2;
      16:      r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/etr_sincos.sv -----
// pipelined sine/cosine of one Q2.13 angle: range reduction, unrolled cordic, narrowing
// depends on etr_pkg; stage enables come from the pipeline control in the top level
module etr_sincos import etr_pkg::*; (
  input  logic                    clk_i,
  input  logic [SinCosStages-1:0] en_i,
  input  angle_t                  angle_i,
  output trig_t                   sin_o,
  output trig_t                   cos_o
);

  localparam cord_t NarrowMax = cord_t'(1 << 20);

  function automatic trig_t narrow_q20(input cord_t v);
    cord_t t;
    cord_t r;
    t = v + cord_t'(512);
    r = t >>> 10;
    if (r > NarrowMax) begin
      r = NarrowMax;
    end else if (r < -NarrowMax) begin
      r = -NarrowMax;
    end
    return r[TrigW-1:0];
  endfunction

  angle_t a_red;
  logic   neg_red;
  zang_t  z0_q;
  logic   neg0_q;

  // fold angles beyond a quarter turn back by pi and flip the sign of the result
  always_comb begin
    if (angle_i > AngHalfPi) begin
      a_red   = angle_i - AngPi;
      neg_red = 1'b1;
    end else if (angle_i < -AngHalfPi) begin
      a_red   = angle_i + AngPi;
      neg_red = 1'b1;
    end else begin
      a_red   = angle_i;
      neg_red = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      z0_q   <= ZW'(a_red) <<< 3;
      neg0_q <= neg_red;
    end
  end

  cord_t x_q   [CordicSteps];
  cord_t y_q   [CordicSteps];
  zang_t z_q   [CordicSteps];
  logic  neg_q [CordicSteps];

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    cord_t x_in;
    cord_t y_in;
    zang_t z_in;
    logic  n_in;

    if (i == 0) begin : g_first
      assign x_in = CordicGain;
      assign y_in = '0;
      assign z_in = z0_q;
      assign n_in = neg0_q;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign n_in = neg_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[i+1]) begin
        if (!z_in[ZW-1]) begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
          z_q[i] <= z_in - atan_q16(i);
        end else begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
          z_q[i] <= z_in + atan_q16(i);
        end
        neg_q[i] <= n_in;
      end
    end
  end

  cord_t x_fin;
  cord_t y_fin;
  trig_t sin_q;
  trig_t cos_q;

  always_comb begin
    if (neg_q[CordicSteps-1]) begin
      x_fin = -x_q[CordicSteps-1];
      y_fin = -y_q[CordicSteps-1];
    end else begin
      x_fin = x_q[CordicSteps-1];
      y_fin = y_q[CordicSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[SinCosStages-1]) begin
      cos_q <= narrow_q20(x_fin);
      sin_q <= narrow_q20(y_fin);
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ----- hdl/euler_to_rotation_matrix_top.sv -----
// heading-attitude-bank euler angles to a 3x3 rotation matrix, fully pipelined
// depends on etr_pkg and etr_sincos (one instance per angle)
//
//   channel   dir  payload                                        width
//   s_axis    in   heading, attitude, bank (Q2.13)                48
//   m_axis    out  m00 m01 m02 m10 m11 m12 m20 m21 m22 (Q1.14)    144
//
// one request per cycle while the output is not stalled; the pipeline has 1 reduction, 17 cordic,
// 1 narrowing and 5 multiply/sum/round stages
// each stage holds its own valid bit and advances when empty or when the stage after it
// advances, so bubbles close up and a stalled output only holds the full stages behind it
// reset clears the valid bits only
module euler_to_rotation_matrix_top import etr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // heading_angle, attitude_angle, bank_angle
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata    // m00, m01, m02, m10, m11, m12, m20, m21, m22
);

  typedef logic signed [2*TrigW-1:0]     prod_t;
  typedef logic signed [WideW-1:0]       wide_t;
  typedef logic signed [2*TrigW-21:0]    hi_t;
  typedef logic signed [2*TrigW+1:0]     hiprod_t;
  typedef logic signed [TrigW+20:0]      loprod_t;

  localparam wide_t RoundQ60 = wide_t'(64'sd1 <<< 45);
  localparam wide_t OutMax   = wide_t'(16384);

  function automatic logic [OutW-1:0] finish_q60(input wide_t v);
    wide_t t;
    wide_t r;
    t = v + RoundQ60;
    r = t >>> 46;
    if (r > OutMax) begin
      r = OutMax;
    end else if (r < -OutMax) begin
      r = -OutMax;
    end
    return r[OutW-1:0];
  endfunction

  // pipeline control
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  assign en[NumStages-1] = !v_q[NumStages-1] || m_axis_tready;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? s_axis_tvalid : v_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NumStages-1];

  // sine and cosine of each angle
  trig_t sh, ch, sa, ca, sb, cb;

  etr_sincos u_heading (
    .clk_i   (clk_i),
    .en_i    (en[SinCosStages-1:0]),
    .angle_i (angle_t'(s_axis_tdata[15:0])),
    .sin_o   (sh),
    .cos_o   (ch)
  );

  etr_sincos u_attitude (
    .clk_i   (clk_i),
    .en_i    (en[SinCosStages-1:0]),
    .angle_i (angle_t'(s_axis_tdata[31:16])),
    .sin_o   (sa),
    .cos_o   (ca)
  );

  etr_sincos u_bank (
    .clk_i   (clk_i),
    .en_i    (en[SinCosStages-1:0]),
    .angle_i (angle_t'(s_axis_tdata[47:32])),
    .sin_o   (sb),
    .cos_o   (cb)
  );

  localparam int P1 = SinCosStages;
  localparam int P2 = SinCosStages + 1;
  localparam int P3 = SinCosStages + 2;
  localparam int P4 = SinCosStages + 3;
  localparam int P5 = SinCosStages + 4;

  // stage p1: the two-factor products
  prod_t chca1_q, shsb1_q, shcb1_q, cacb1_q, casb1_q, shca1_q, chsb1_q, chcb1_q;
  prod_t chsa1_q, shsa1_q;
  trig_t sa1_q, sb1_q, cb1_q;

  always_ff @(posedge clk_i) begin
    if (en[P1]) begin
      chca1_q <= ch * ca;
      shsb1_q <= sh * sb;
      shcb1_q <= sh * cb;
      cacb1_q <= ca * cb;
      casb1_q <= ca * sb;
      shca1_q <= sh * ca;
      chsb1_q <= ch * sb;
      chcb1_q <= ch * cb;
      chsa1_q <= ch * sa;
      shsa1_q <= sh * sa;
      sa1_q   <= sa;
      sb1_q   <= sb;
      cb1_q   <= cb;
    end
  end

  // stage p2: third factor, with the pair product split into a high part and its low 20 bits
  hi_t   chsa_hi, shsa_hi;
  trig_t chsa_lo, shsa_lo;

  assign chsa_hi = hi_t'(chsa1_q >>> 20);
  assign shsa_hi = hi_t'(shsa1_q >>> 20);
  assign chsa_lo = trig_t'({2'b00, chsa1_q[19:0]});
  assign shsa_lo = trig_t'({2'b00, shsa1_q[19:0]});

  hiprod_t chsacb_hi_q, chsasb_hi_q, shsacb_hi_q, shsasb_hi_q;
  loprod_t chsacb_lo_q, chsasb_lo_q, shsacb_lo_q, shsasb_lo_q;
  prod_t   chca2_q, shsb2_q, shcb2_q, cacb2_q, casb2_q, shca2_q, chsb2_q, chcb2_q;
  trig_t   sa2_q;

  always_ff @(posedge clk_i) begin
    if (en[P2]) begin
      chsacb_hi_q <= chsa_hi * cb1_q;
      chsasb_hi_q <= chsa_hi * sb1_q;
      shsacb_hi_q <= shsa_hi * cb1_q;
      shsasb_hi_q <= shsa_hi * sb1_q;
      chsacb_lo_q <= chsa_lo * cb1_q;
      chsasb_lo_q <= chsa_lo * sb1_q;
      shsacb_lo_q <= shsa_lo * cb1_q;
      shsasb_lo_q <= shsa_lo * sb1_q;
      chca2_q <= chca1_q;
      shsb2_q <= shsb1_q;
      shcb2_q <= shcb1_q;
      cacb2_q <= cacb1_q;
      casb2_q <= casb1_q;
      shca2_q <= shca1_q;
      chsb2_q <= chsb1_q;
      chcb2_q <= chcb1_q;
      sa2_q   <= sa1_q;
    end
  end

  // stage p3: recombine the three-factor products in Q.60
  wide_t chsacb3_q, chsasb3_q, shsacb3_q, shsasb3_q;
  prod_t chca3_q, shsb3_q, shcb3_q, cacb3_q, casb3_q, shca3_q, chsb3_q, chcb3_q;
  trig_t sa3_q;

  always_ff @(posedge clk_i) begin
    if (en[P3]) begin
      chsacb3_q <= (wide_t'(chsacb_hi_q) <<< 20) + wide_t'(chsacb_lo_q);
      chsasb3_q <= (wide_t'(chsasb_hi_q) <<< 20) + wide_t'(chsasb_lo_q);
      shsacb3_q <= (wide_t'(shsacb_hi_q) <<< 20) + wide_t'(shsacb_lo_q);
      shsasb3_q <= (wide_t'(shsasb_hi_q) <<< 20) + wide_t'(shsasb_lo_q);
      chca3_q <= chca2_q;
      shsb3_q <= shsb2_q;
      shcb3_q <= shcb2_q;
      cacb3_q <= cacb2_q;
      casb3_q <= casb2_q;
      shca3_q <= shca2_q;
      chsb3_q <= chsb2_q;
      chcb3_q <= chcb2_q;
      sa3_q   <= sa2_q;
    end
  end

  // stage p4: matrix entries in Q.60
  wide_t ent_q [NumEntries];

  always_ff @(posedge clk_i) begin
    if (en[P4]) begin
      ent_q[0] <= wide_t'(chca3_q) <<< 20;
      ent_q[1] <= (wide_t'(shsb3_q) <<< 20) - chsacb3_q;
      ent_q[2] <= chsasb3_q + (wide_t'(shcb3_q) <<< 20);
      ent_q[3] <= wide_t'(sa3_q) <<< 40;
      ent_q[4] <= wide_t'(cacb3_q) <<< 20;
      ent_q[5] <= -(wide_t'(casb3_q) <<< 20);
      ent_q[6] <= -(wide_t'(shca3_q) <<< 20);
      ent_q[7] <= shsacb3_q + (wide_t'(chsb3_q) <<< 20);
      ent_q[8] <= (wide_t'(chcb3_q) <<< 20) - shsasb3_q;
    end
  end

  // stage p5: round half up and saturate to Q1.14, output register
  logic [OutW-1:0] out_q [NumEntries];

  always_ff @(posedge clk_i) begin
    if (en[P5]) begin
      for (int e = 0; e < NumEntries; e++) begin
        out_q[e] <= finish_q60(ent_q[e]);
      end
    end
  end

  for (genvar e = 0; e < NumEntries; e++) begin : g_out
    assign m_axis_tdata[e*OutW +: OutW] = out_q[e];
  end

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for euler_to_rotation_matrix_top: angle triples in, 3x3 matrix out
// depends on etr_pkg for widths and stage counts; predicts every entry with its own cordic

module tb_top;
  import etr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;
  localparam int LongHold      = 300;
  localparam int TailCycles    = 2 * NumStages;

  localparam longint QuarterTurn = 12868;
  localparam longint HalfTurn    = 25736;
  localparam longint GainQ30     = 652032874;
  localparam longint UnitQ20     = 64'sd1 << 20;
  localparam longint EntryMax    = 16384;
  localparam longint ArcTanQ16 [CordicSteps] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2, 1
  };

  typedef logic signed [OutW-1:0] entry_t;
  typedef struct {
    entry_t e [NumEntries];
  } rot_matrix_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [47:0]  s_tdata  = '0;
  logic         m_tready = 1'b0;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic [143:0] m_axis_tdata;

  rot_matrix_t expected_matrices [$];
  int          mismatch_count = 0;
  int          hold_requests  = 0;
  string       entry_name [NumEntries] = '{
    "m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"
  };

  euler_to_rotation_matrix_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // sine and cosine in Q.20 of a Q2.13 angle
  function automatic void trig_of(input angle_t ang, output longint s, output longint c);
    longint a, x, y, z, dx, dy;
    bit     flip;
    a    = ang;
    flip = 1'b0;
    if (a > QuarterTurn) begin
      a    = a - HalfTurn;
      flip = 1'b1;
    end else if (a < -QuarterTurn) begin
      a    = a + HalfTurn;
      flip = 1'b1;
    end
    x = GainQ30;
    y = 0;
    z = a * 8;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ArcTanQ16[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ArcTanQ16[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x + 512) >>> 10;
    s = (y + 512) >>> 10;
    if (c > UnitQ20) c = UnitQ20;
    if (c < -UnitQ20) c = -UnitQ20;
    if (s > UnitQ20) s = UnitQ20;
    if (s < -UnitQ20) s = -UnitQ20;
  endfunction

  // Q.60 sum down to a saturated Q1.14 entry
  function automatic entry_t round_entry(input longint v);
    longint r;
    r = (v + (64'sd1 << 45)) >>> 46;
    if (r > EntryMax) r = EntryMax;
    if (r < -EntryMax) r = -EntryMax;
    return entry_t'(r);
  endfunction

  function automatic rot_matrix_t rotation_of(input angle_t h, input angle_t a, input angle_t b);
    longint      sh, ch, sa, ca, sb, cb;
    rot_matrix_t m;
    trig_of(h, sh, ch);
    trig_of(a, sa, ca);
    trig_of(b, sb, cb);
    m.e[0] = round_entry(ch * ca * UnitQ20);
    m.e[1] = round_entry(sh * sb * UnitQ20 - ch * sa * cb);
    m.e[2] = round_entry(ch * sa * sb + sh * cb * UnitQ20);
    m.e[3] = round_entry(sa * UnitQ20 * UnitQ20);
    m.e[4] = round_entry(ca * cb * UnitQ20);
    m.e[5] = round_entry(-(ca * sb * UnitQ20));
    m.e[6] = round_entry(-(sh * ca * UnitQ20));
    m.e[7] = round_entry(sh * sa * cb + ch * sb * UnitQ20);
    m.e[8] = round_entry(-(sh * sa * sb) + ch * cb * UnitQ20);
    return m;
  endfunction

  function automatic angle_t random_angle();
    int v;
    case ($urandom_range(0, 9))
      6: v = int'($urandom_range(0, 65535)) - 32768;
      7: begin
        v = int'(QuarterTurn) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1)) v = -v;
      end
      8: begin
        v = int'(HalfTurn) + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1)) v = -v;
      end
      9: v = int'($urandom_range(0, 64)) - 32;
      default: v = int'($urandom_range(0, 2 * HalfTurn)) - int'(HalfTurn);
    endcase
    return v[AngW-1:0];
  endfunction

  // queues the matrix expected for an accepted request
  task automatic record_expected(input rot_matrix_t m);
    expected_matrices.insert(expected_matrices.size(), m);
  endtask

  // offers one request and waits for it to be taken; valid stays high afterwards
  task automatic send_request(input angle_t h, input angle_t a, input angle_t b);
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a, h};
    do @(posedge clk_i); while (!s_axis_tready);
    record_expected(rotation_of(h, a, b));
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    while (expected_matrices.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_corner_angles();
    send_request(16'sd0, 16'sd0, 16'sd0);
    send_request(16'sd12868, 16'sd12868, 16'sd12868);
    send_request(-16'sd12868, -16'sd12868, -16'sd12868);
    send_request(16'sd12869, -16'sd12869, 16'sd12869);
    send_request(16'sd25736, -16'sd25736, 16'sd25736);
    idle_sender(3);
    send_request(16'sd25737, -16'sd25737, 16'sd6434);
    send_request(16'sd32767, -16'sd32768, 16'sd0);
    send_request(-16'sd32768, 16'sd32767, -16'sd1);
    send_request(16'sd1, -16'sd1, 16'sd32767);
    idle_sender(1);
    send_request(16'sd6434, -16'sd6434, 16'sd19302);
    // attitude at plus and minus a quarter turn: gimbal lock
    send_request(16'sd0, 16'sd12868, 16'sd0);
    send_request(16'sd0, -16'sd12868, 16'sd8000);
    send_request(-16'sd19302, 16'sd3217, -16'sd25736);
    send_request(16'sd21845, -16'sd21846, 16'sd12345);
    send_request(-16'sd21846, 16'sd21845, -16'sd12345);
    idle_sender(2);
  endtask

  // output held off for a long stretch while requests keep coming, so the pipe backs up
  task automatic test_output_hold();
    hold_requests = hold_requests + 1;
    repeat (80) send_request(random_angle(), random_angle(), random_angle());
    idle_sender(1);
  endtask

  // sender goes quiet until the pipe has fully drained, then resumes
  task automatic test_drain_pause();
    repeat (40) send_request(random_angle(), random_angle(), random_angle());
    idle_sender(1);
    wait_for_results();
    repeat (40) send_request(random_angle(), random_angle(), random_angle());
    idle_sender(1);
  endtask

  task automatic test_random_angles(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 48);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_request(random_angle(), random_angle(), random_angle());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 15));
    end
    idle_sender(1);
  endtask

  // receiver stall pattern, plus the long hold asked for by the test sequence
  always @(posedge clk_i) begin : rx_stall
    static int       hold_served = 0;
    static int       hold_left   = 0;
    static int       mode_left   = 0;
    static int       phase       = 0;
    static rx_mode_e rx_mode     = RX_STEADY;
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left   = LongHold;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(32, 200);
    end else begin
      mode_left = mode_left - 1;
    end
    phase = phase + 1;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY:   m_tready <= 1'b1;
        RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: m_tready <= ((phase % 5) < 3);
        default:     m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : matrix_check
    rot_matrix_t want;
    entry_t      got;
    if (rst_ni && m_axis_tvalid && m_tready) begin
      if (expected_matrices.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_matrices.pop_front();
        for (int k = 0; k < NumEntries; k++) begin
          got = m_axis_tdata[OutW*k +: OutW];
          if (got !== want.e[k]) begin
            $error("%s: expected %0d, got %0d", entry_name[k], want.e[k], got);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    static int quiet_cycles = 0;
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_angles();
    test_output_hold();
    test_drain_pause();
    test_random_angles(1100);
    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_matrices.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
